// ===== src/mwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-word subsequence counter package
// Shared field widths, parameter defaults, command codes and sequencer states.
// ----------------------------------------------------------------------------
package mwsc_pkg;

	// Field widths of the request and result channels.
	localparam int CMD_W   = 2;
	localparam int SYM_W   = 8;
	localparam int COUNT_W = 7;

	// Default capacity of the pattern store.
	localparam int MAX_WORDS_DEF    = 64;
	localparam int MAX_WORD_LEN_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_TEXT   = 2'd2,
		CMD_REPORT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COUNT,
		ST_DONE
	} state_t;

endpackage

// ===== src/mwsc_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one command with its symbol and flag.
// ----------------------------------------------------------------------------
interface mwsc_req_if import mwsc_pkg::*; ();

	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [SYM_W-1:0] symbol;
	logic             word_end;

	modport source (output valid, output command, output symbol, output word_end,
		input ready);
	modport sink (input valid, input command, input symbol, input word_end,
		output ready);

endinterface

// ===== src/mwsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one count report.
// ----------------------------------------------------------------------------
interface mwsc_rsp_if import mwsc_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] matched_count;
	logic [COUNT_W-1:0] words_loaded;
	logic               overflow;

	modport source (output valid, output matched_count, output words_loaded,
		output overflow, input ready);
	modport sink (input valid, input matched_count, input words_loaded,
		input overflow, output ready);

endinterface

// ===== src/mwsc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mwsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/multi_word_subsequence_counter_unit.sv =====
// ----------------------------------------------------------------------------
// Multi-word subsequence counter
// Holds a set of pattern words and counts how many occur as subsequences of
// a text stream.
// ----------------------------------------------------------------------------
// Usage. Requests arrive on the request channel, each carrying a command, a
// symbol and a word-end flag. A clear empties the store, a load appends one
// character to the word being built (word_end closes it), a text symbol
// advances every stored word whose next unmatched character equals it, and
// a report returns one result on the result channel; no other request gives
// a result.
// Timing. Clear and load requests complete in the cycle they are accepted. A text
// symbol sweeps the stored words through a three-stage sequencer (word read,
// character read, then compare and write-back), one word per cycle, and the
// block takes no new request until the sweep ends. A report sweeps the same
// words once more before it presents its result.
// Reset. After reset the store is empty and the overflow flag is clear; no
// clearing pass is needed, so requests are taken at once.
// Stalls. The result sits in an output register; further requests are still
// taken while it waits. A second report that finishes while the first is
// still held waits in its final state until the result register frees.
// ----------------------------------------------------------------------------
module multi_word_subsequence_counter_unit import mwsc_pkg::*; #(
	parameter int MAX_WORDS    = MAX_WORDS_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mwsc_req_if.sink   request,
	mwsc_rsp_if.source result
);

	// Widths derived from the store capacity.
	localparam int CHAR_DEPTH = MAX_WORDS * MAX_WORD_LEN;
	localparam int IW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCW = $clog2(MAX_WORDS + 1);
	localparam int PW  = $clog2(MAX_WORD_LEN + 1);
	localparam int CAW = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;
	localparam int CBW = $clog2(CHAR_DEPTH + 1);

	// Control state.
	state_t         state_q, state_d;
	logic [WCW-1:0] word_total_q;
	logic [PW-1:0]  fill_q;
	logic           overflow_q;
	logic [CBW-1:0] load_base_q;
	logic [WCW-1:0] idx_q;
	logic [CBW-1:0] scan_base_q;
	logic           v_s1;
	logic           v_s2;
	logic [WCW-1:0] cnt_q;
	logic           out_valid_q;

	// Payload registers.
	logic [SYM_W-1:0]   sym_q;
	logic [IW-1:0]      w_s1;
	logic [CBW-1:0]     base_s1;
	logic [IW-1:0]      w_s2;
	logic [PW-1:0]      p_s2;
	logic [PW-1:0]      len_s2;
	logic               hit_s2;
	logic [COUNT_W-1:0] matched_q;
	logic [COUNT_W-1:0] loaded_q;

	// Memory ports.
	logic              char_we;
	logic [CAW-1:0]    char_waddr;
	logic [SYM_W-1:0]  char_rdata;
	logic [CAW-1:0]    char_raddr;
	logic              word_we;
	logic [IW-1:0]     word_waddr;
	logic [2*PW-1:0]   word_wdata;
	logic [2*PW-1:0]   word_rdata;

	// Decoded request and datapath helpers.
	logic               accept;
	cmd_t               cmd;
	logic               store_full;
	logic               room;
	logic [PW-1:0]      fill_inc;
	logic               issue;
	logic               scan_done;
	logic               count_done;
	logic               out_load;
	logic [PW-1:0]      prog_rd;
	logic [PW-1:0]      len_rd;
	logic               hit_s1;
	logic [CBW-1:0]     char_rsum;
	logic [CBW-1:0]     char_wsum;
	logic [COUNT_W+WCW-1:0] cnt_ext;
	logic [COUNT_W+WCW-1:0] total_ext;

	assign accept     = request.valid && request.ready;
	assign cmd        = cmd_t'(request.command);
	assign store_full = (word_total_q == WCW'(MAX_WORDS));
	assign room       = (fill_q < PW'(MAX_WORD_LEN));
	assign fill_inc   = fill_q + PW'(1);

	// The word store keeps each word's length in the upper half and its
	// match progress in the lower half of one entry.
	assign len_rd  = word_rdata[2*PW-1:PW];
	assign prog_rd = word_rdata[PW-1:0];
	assign hit_s1  = (prog_rd < len_rd);

	// A word that is already complete still issues a read, aimed at its own
	// first character; the result is then ignored.
	assign char_rsum  = base_s1 + (hit_s1 ? CBW'(prog_rd) : CBW'(0));
	assign char_raddr = char_rsum[CAW-1:0];
	assign char_wsum  = load_base_q + CBW'(fill_q);
	assign char_waddr = char_wsum[CAW-1:0];

	// Sweeps issue one word read a cycle until every stored word is visited.
	assign issue      = ((state_q == ST_SCAN) || (state_q == ST_COUNT)) &&
		(idx_q != word_total_q);
	assign scan_done  = !issue && !v_s1 && !v_s2;
	assign count_done = !issue && !v_s1;
	assign out_load   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign cnt_ext   = {{COUNT_W{1'b0}}, cnt_q};
	assign total_ext = {{COUNT_W{1'b0}}, word_total_q};

	// Sequencer: next state and memory write controls.
	always_comb begin
		state_d       = state_q;
		request.ready = (state_q == ST_IDLE);
		char_we       = 1'b0;
		word_we       = 1'b0;
		word_waddr    = w_s2;
		word_wdata    = {len_s2, p_s2 + PW'(1)};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_CLEAR: begin
							state_d = ST_IDLE;
						end
						CMD_LOAD: begin
							// A word closes with the length it has after this
							// character, and starts with no progress.
							char_we    = !store_full && room;
							word_we    = !store_full && request.word_end;
							word_waddr = word_total_q[IW-1:0];
							word_wdata = {(room ? fill_inc : fill_q), PW'(0)};
						end
						CMD_TEXT: begin
							state_d = ST_SCAN;
						end
						CMD_REPORT: begin
							state_d = ST_COUNT;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// Write back one position of progress when the next unmatched
				// character equals the text symbol.
				word_we = v_s2 && hit_s2 && (char_rdata == sym_q);
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_COUNT: begin
				if (count_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Store bookkeeping, sweep counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_total_q <= '0;
			fill_q       <= '0;
			overflow_q   <= 1'b0;
			load_base_q  <= '0;
			idx_q        <= '0;
			scan_base_q  <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1 && (state_q == ST_SCAN);
			if (issue) begin
				idx_q       <= idx_q + WCW'(1);
				scan_base_q <= scan_base_q + CBW'(MAX_WORD_LEN);
			end
			if ((state_q == ST_COUNT) && v_s1 && (prog_rd == len_rd)) begin
				cnt_q <= cnt_q + WCW'(1);
			end
			if (accept) begin
				idx_q       <= '0;
				scan_base_q <= '0;
				cnt_q       <= '0;
				unique case (cmd)
					CMD_CLEAR: begin
						word_total_q <= '0;
						fill_q       <= '0;
						overflow_q   <= 1'b0;
						load_base_q  <= '0;
					end
					CMD_LOAD: begin
						if (store_full) begin
							overflow_q <= 1'b1;
						end else begin
							if (!room) begin
								overflow_q <= 1'b1;
							end
							if (request.word_end) begin
								word_total_q <= word_total_q + WCW'(1);
								fill_q       <= '0;
								load_base_q  <= load_base_q + CBW'(MAX_WORD_LEN);
							end else if (room) begin
								fill_q <= fill_inc;
							end
						end
					end
					CMD_TEXT: begin
					end
					CMD_REPORT: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sweep pipeline and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q <= request.symbol;
		end
		w_s1    <= idx_q[IW-1:0];
		base_s1 <= scan_base_q;
		w_s2    <= w_s1;
		p_s2    <= prog_rd;
		len_s2  <= len_rd;
		hit_s2  <= hit_s1;
		if (out_load) begin
			matched_q <= cnt_ext[COUNT_W-1:0];
			loaded_q  <= total_ext[COUNT_W-1:0];
		end
	end

	// The overflow flag only changes on requests, which are not taken while a
	// report is in flight, so it is sampled into the result with the counts.
	logic overflow_out_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			overflow_out_q <= overflow_q;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.matched_count = matched_q;
	assign result.words_loaded  = loaded_q;
	assign result.overflow      = overflow_out_q;

	mwsc_ram #(
		.WIDTH(SYM_W),
		.DEPTH(CHAR_DEPTH)
	) u_char_ram (
		.clk  (clk),
		.we   (char_we),
		.waddr(char_waddr),
		.wdata(request.symbol),
		.raddr(char_raddr),
		.rdata(char_rdata)
	);

	mwsc_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WORDS)
	) u_word_ram (
		.clk  (clk),
		.we   (word_we),
		.waddr(word_waddr),
		.wdata(word_wdata),
		.raddr(idx_q[IW-1:0]),
		.rdata(word_rdata)
	);

endmodule
